// ===== rtl/ssel_pkg.sv =====
// Shared types and constants for the sprite scanline select block.
// No dependencies; every other file in rtl/ imports this package.
package ssel_pkg;

  localparam int MAX_PER_LINE_DEF = 10;
  localparam int ENTRY_COUNT_DEF  = 40;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [8:0] SPR_H_SHORT    = 9'd8;
  localparam logic [8:0] SPR_H_TALL     = 9'd16;
  localparam logic [7:0] TILE_EVEN_MASK = 8'hFE;

  // Attribute flag byte bit positions.
  localparam int FLAG_PRIO  = 7;
  localparam int FLAG_YFLIP = 6;
  localparam int FLAG_XFLIP = 5;
  localparam int FLAG_PAL   = 4;

  typedef struct packed {
    logic       first_of_line;
    logic [7:0] scanline;
    logic [5:0] entry_index;
    logic [7:0] pos_y;
    logic [7:0] pos_x;
    logic [7:0] tile_byte;
    logic [7:0] flag_byte;
  } ssel_req_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [5:0] sel_index;
    logic [7:0] sel_x;
    logic [7:0] row_tile;
    logic [2:0] row_in_tile;
    logic       mirror_x;
    logic       palette_sel;
    logic       behind_bg;
  } ssel_res_t;

  // Selected entry as it travels from the front to the back.
  typedef struct packed {
    logic [3:0] slot;
    logic [5:0] index;
    logic [7:0] pos_x;
    logic [7:0] tile;
    logic [3:0] row;
    logic       yflip;
    logic       xflip;
    logic       pal;
    logic       prio;
  } ssel_sel_t;

endpackage

// ===== rtl/ssel_front.sv =====
// Front of the sprite scanline select: accepts requests, tests line range,
// keeps the per-line selection count. Depends on ssel_pkg.
module ssel_front import ssel_pkg::*; #(
  parameter int MAX_PER_LINE = MAX_PER_LINE_DEF,
  parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tall,
  input  logic      take,
  input  ssel_req_t request,
  output logic      sel_push,
  output ssel_sel_t sel_item
);

  logic [3:0] picked_count;
  logic [3:0] picked_count_next;
  logic [3:0] count_base;
  logic [8:0] line9;
  logic [8:0] top9;
  logic [8:0] height;
  logic [7:0] diff;
  logic       hit;

  always_comb begin
    count_base = request.first_of_line ? 4'd0 : picked_count;
    line9      = {1'b0, request.scanline};
    top9       = {1'b0, request.pos_y};
    height     = tall ? SPR_H_TALL : SPR_H_SHORT;
    diff       = request.scanline - request.pos_y;
    hit = ({1'b0, request.entry_index} < 7'(ENTRY_COUNT)) &&
          (top9 <= line9) && (line9 < top9 + height) &&
          (count_base < 4'(MAX_PER_LINE));
    sel_push = take && hit;
    picked_count_next = picked_count;
    if (take) begin
      picked_count_next = hit ? count_base + 4'd1 : count_base;
    end
    sel_item.slot  = count_base;
    sel_item.index = request.entry_index;
    sel_item.pos_x = request.pos_x;
    sel_item.tile  = request.tile_byte;
    sel_item.row   = diff[3:0];
    sel_item.yflip = request.flag_byte[FLAG_YFLIP];
    sel_item.xflip = request.flag_byte[FLAG_XFLIP];
    sel_item.pal   = request.flag_byte[FLAG_PAL];
    sel_item.prio  = request.flag_byte[FLAG_PRIO];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      picked_count <= 4'd0;
    end else begin
      picked_count <= picked_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    picked_count <= 4'(MAX_PER_LINE))
    else $error("selection count above line limit");

endmodule

// ===== rtl/ssel_fifo.sv =====
// Short queue between front and back of the sprite scanline select.
// Flop storage, combinational head read. Depends on ssel_pkg.
module ssel_fifo import ssel_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  ssel_sel_t wr_data,
  input  logic      rd_en,
  output ssel_sel_t rd_data,
  output logic      full,
  output logic      not_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ssel_sel_t           mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !rd_en |-> !wr_en)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/ssel_back.sv =====
// Back of the sprite scanline select: applies y flip, picks the tile half,
// holds the finished result in an output register. Depends on ssel_pkg.
module ssel_back import ssel_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      tall,
  input  logic      sel_avail,
  input  ssel_sel_t sel_item,
  output logic      sel_pop,
  output logic      empty,
  input  logic      pop,
  output ssel_res_t result
);

  logic      res_valid;
  logic      load;
  logic [3:0] row_f;
  ssel_res_t res_next;

  assign empty   = !res_valid;
  assign load    = sel_avail && (!res_valid || pop);
  assign sel_pop = load;

  always_comb begin
    // Flip over the full sprite height; bit 3 only matters for tall sprites.
    row_f = sel_item.yflip ? ~sel_item.row : sel_item.row;
    res_next.slot        = sel_item.slot;
    res_next.sel_index   = sel_item.index;
    res_next.sel_x       = sel_item.pos_x;
    res_next.row_tile    = tall ? ((sel_item.tile & TILE_EVEN_MASK) | {7'd0, row_f[3]})
                                : sel_item.tile;
    res_next.row_in_tile = row_f[2:0];
    res_next.mirror_x    = sel_item.xflip;
    res_next.palette_sel = sel_item.pal;
    res_next.behind_bg   = sel_item.prio;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/sprite_scanline_select.sv =====
// Top level of the sprite scanline select block.
// Depends on ssel_pkg, ssel_front, ssel_fifo and ssel_back.
//
// Streams sprite entries, one request per clock unless full, and emits one
// result for every entry whose vertical span [pos_y, pos_y+height) covers
// the scanline, up to MAX_PER_LINE results per line (first_of_line on a
// request restarts the count). Entries with an index at or above
// ENTRY_COUNT are dropped. Both sides sustain one request and one result
// per cycle unless full is high or pop is held low; a result goes from
// the front compare into the queue, then into the back's output register.
// The QUEUE_DEPTH-entry queue between front and back lets the producer
// keep pushing while the consumer stalls; full rises only when that queue
// is full. tall_sprites selects 16-row sprites and must be written only
// while no request is in flight. No clearing pass after reset.
module sprite_scanline_select import ssel_pkg::*; #(
  parameter int MAX_PER_LINE = MAX_PER_LINE_DEF,
  parameter int ENTRY_COUNT  = ENTRY_COUNT_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  // request side
  input  logic      push,
  output logic      full,
  input  ssel_req_t request,
  // result side
  output logic      empty,
  input  logic      pop,
  output ssel_res_t result,
  // configuration
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic      tall_sprites;
  logic      take;
  logic      sel_push;
  logic      sel_pop;
  logic      sel_avail;
  ssel_sel_t sel_in;
  ssel_sel_t sel_out;

  // Hold the sprite height setting.
  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_wr_en) begin
      tall_sprites <= cfg_wr_data;
    end
  end

  // A request is taken whenever the queue has room.
  assign take = push && !full;

  ssel_front #(
    .MAX_PER_LINE (MAX_PER_LINE),
    .ENTRY_COUNT  (ENTRY_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .tall     (tall_sprites),
    .take     (take),
    .request  (request),
    .sel_push (sel_push),
    .sel_item (sel_in)
  );

  ssel_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (sel_push),
    .wr_data   (sel_in),
    .rd_en     (sel_pop),
    .rd_data   (sel_out),
    .full      (full),
    .not_empty (sel_avail)
  );

  // Advance the queue head into the output register when it is free.
  ssel_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tall      (tall_sprites),
    .sel_avail (sel_avail),
    .sel_item  (sel_out),
    .sel_pop   (sel_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.slot < 4'(MAX_PER_LINE)))
    else $error("result slot beyond line limit");

endmodule
